>>> rtl/core/ufgm_pkg.sv
`default_nettype none

package ufgm_pkg;

  localparam int unsigned PointCount = 4096;
  localparam int unsigned IdxW       = $clog2(PointCount);
  localparam int unsigned FieldW     = 12;

  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [FieldW-1:0] field_t;

  typedef enum logic [3:0] {
    StInit = 4'b0001,
    StIdle = 4'b0010,
    StStep = 4'b0100,
    StWait = 4'b1000
  } walk_state_e;

  typedef struct packed {
    logic we;
    idx_t waddr;
    idx_t wdata;
    idx_t raddr_a;
    idx_t raddr_b;
  } ram_req_t;

  typedef struct packed {
    logic   linked;
    field_t anchor;
  } result_t;

  typedef struct packed {
    logic busy;
    logic step_on;
  } walk_stat_t;

  // PointCount is a power of two, so the fold is a truncation.
  function automatic idx_t fold_index(input field_t v);
    return idx_t'(v);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ufgm_ram.sv
`default_nettype none

module ufgm_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 12,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [Width-1:0] rdata_a_o,
  output logic      [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

>>> rtl/core/ufgm_walk.sv
`default_nettype none

module ufgm_walk
  import ufgm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire field_t     member_i,
  input  wire field_t     master_i,
  input  wire logic       group_start_i,
  output logic            in_ready_o,
  input  wire logic       out_free_i,
  input  wire idx_t       rdata_a_i,
  input  wire idx_t       rdata_b_i,
  output ram_req_t        ram_req_o,
  output logic            res_valid_o,
  output result_t         res_o,
  output walk_stat_t      stat_o
);

  walk_state_e state_q, state_d;
  idx_t        r1_q, r1_d;
  idx_t        r2_q, r2_d;
  idx_t        anchor_q, anchor_d;
  idx_t        cnt_q, cnt_d;
  result_t     pend_q, pend_d;

  idx_t        p1, p2;
  idx_t        anchor_new;
  logic        done;
  logic        linked;

  assign p1 = rdata_a_i;
  assign p2 = rdata_b_i;

  always_comb begin
    state_d           = state_q;
    r1_d              = r1_q;
    r2_d              = r2_q;
    anchor_d          = anchor_q;
    cnt_d             = cnt_q;
    pend_d            = pend_q;
    in_ready_o        = 1'b0;
    res_valid_o       = 1'b0;
    res_o             = pend_q;
    done              = 1'b0;
    linked            = 1'b0;
    anchor_new        = anchor_q;
    ram_req_o.we      = 1'b0;
    ram_req_o.waddr   = r1_q;
    ram_req_o.wdata   = p2;

    case (state_q)
      StInit: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = cnt_q;
        ram_req_o.wdata = cnt_q;
        cnt_d           = cnt_q + idx_t'(1);
        if (cnt_q == idx_t'(PointCount - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          anchor_new = group_start_i ? fold_index(master_i) : anchor_q;
          anchor_d   = anchor_new;
          r1_d       = fold_index(member_i);
          r2_d       = anchor_new;
          state_d    = StStep;
        end
      end
      StStep: begin
        if (p1 == p2) begin
          done = 1'b1;
        end else if (p1 < p2) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = r1_q;
          ram_req_o.wdata = p2;
          if (p1 == r1_q) begin
            anchor_d = p2;
            linked   = 1'b1;
            done     = 1'b1;
          end else begin
            r1_d = p1;
          end
        end else begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = r2_q;
          ram_req_o.wdata = p1;
          if (p2 == r2_q) begin
            anchor_d = p1;
            linked   = 1'b1;
            done     = 1'b1;
          end else begin
            r2_d = p2;
          end
        end
        if (done) begin
          pend_d.linked = linked;
          pend_d.anchor = field_t'(anchor_d);
          if (out_free_i) begin
            res_valid_o = 1'b1;
            res_o       = pend_d;
            state_d     = StIdle;
          end else begin
            state_d = StWait;
          end
        end
      end
      StWait: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StInit;
      end
    endcase

    ram_req_o.raddr_a = r1_d;
    ram_req_o.raddr_b = r2_d;
  end

  assign stat_o.busy    = (state_q != StIdle);
  assign stat_o.step_on = (state_q == StStep) && !done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StInit;
      cnt_q    <= '0;
      anchor_q <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      anchor_q <= anchor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q   <= r1_d;
    r2_q   <= r2_d;
    pend_q <= pend_d;
  end

endmodule

`default_nettype wire

>>> rtl/core/rem_union_find_group_merge.sv
// Walk: the result lands in the output register once the walk that follows the
//   taken transfer ends (one parent-table read pair and at most one write per step).
// Flow: one item at a time; the walk waits in StWait while the output register is
//   full, and the number of walk steps is set by the parent table.
// Reset: anchor clears to zero; a clearing pass then writes the identity map into
//   the parent table while s_axis_tready stays low.
`default_nettype none

module rem_union_find_group_merge
  import ufgm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // member_point[11:0], master_point[23:12]
  input  wire logic        s_axis_tuser,   // group_start
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,   // anchor_after[11:0], zero[15:12]
  output logic             m_axis_tuser    // linked
);

  ram_req_t   ram_req;
  idx_t       rdata_a;
  idx_t       rdata_b;
  logic       res_valid;
  result_t    res;
  walk_stat_t stat;
  logic       out_free;
  logic       out_vld_q;
  result_t    out_q;

  assign out_free = !out_vld_q || m_axis_tready;

  ufgm_ram #(
    .Depth (PointCount),
    .Width (IdxW)
  ) u_parent_ram (
    .clk_i     (clk_i),
    .we_i      (ram_req.we),
    .waddr_i   (ram_req.waddr),
    .wdata_i   (ram_req.wdata),
    .raddr_a_i (ram_req.raddr_a),
    .raddr_b_i (ram_req.raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  ufgm_walk u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .member_i      (s_axis_tdata[11:0]),
    .master_i      (s_axis_tdata[23:12]),
    .group_start_i (s_axis_tuser),
    .in_ready_o    (s_axis_tready),
    .out_free_i    (out_free),
    .rdata_a_i     (rdata_a),
    .rdata_b_i     (rdata_b),
    .ram_req_o     (ram_req),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .stat_o        (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_q.anchor};
  assign m_axis_tuser  = out_q.linked;

  a_res_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> out_free)
    else $error("result issued while output register is occupied");

  a_no_step_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.step_on && ram_req.we) |->
      (ram_req.waddr != ram_req.raddr_a) && (ram_req.waddr != ram_req.raddr_b))
    else $error("walk step reads the entry it writes");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.busy |-> !s_axis_tready)
    else $error("input ready while walk or clearing pass is active");

endmodule

`default_nettype wire
